// ===== hw/rtl/cia_pkg.sv =====
package cia_pkg;

   localparam int DataWidthDefault = 64;
   localparam int FieldWidth = 64;
   localparam int QueueDepthDefault = 2;

   typedef enum logic [3:0] {
      ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
      ACT_MOD = 4'd4, ACT_POW = 4'd5, ACT_SHL = 4'd6, ACT_SHR = 4'd7,
      ACT_NOT = 4'd8, ACT_AND = 4'd9, ACT_OR = 4'd10, ACT_XOR = 4'd11,
      ACT_NEG = 4'd12, ACT_RSV13 = 4'd13, ACT_RSV14 = 4'd14, ACT_RSV15 = 4'd15
   } action_type;

   typedef enum logic [2:0] {
      ERR_NONE = 3'd0, ERR_OVF = 3'd1, ERR_DIV0 = 3'd2,
      ERR_NEGEXP = 3'd3, ERR_NEGSHIFT = 3'd4,
      ERR_RSV5 = 3'd5, ERR_RSV6 = 3'd6, ERR_RSV7 = 3'd7
   } error_type;

   typedef struct packed {
      logic [3:0]             action;
      logic signed [FieldWidth-1:0] operand_a;
      logic signed [FieldWidth-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [FieldWidth-1:0] value;
      logic [2:0]             error_code;
   } rsp_type;

   // Work classes assigned by the front end.
   typedef enum logic [1:0] {
      CLS_DONE = 2'd0,   // result settled in the front end
      CLS_MUL  = 2'd1,
      CLS_DIV  = 2'd2,
      CLS_POW  = 2'd3
   } class_type;

   typedef struct packed {
      class_type              cls;
      logic                   want_rem;
      logic signed [FieldWidth-1:0] a;
      logic signed [FieldWidth-1:0] b;
      logic signed [FieldWidth-1:0] value;
      logic [2:0]             error_code;
   } job_type;

endpackage

// ===== hw/rtl/cia_front.sv =====
module cia_front #(
   parameter int DataWidth = cia_pkg::DataWidthDefault
) (
   input  cia_pkg::req_type req,
   output cia_pkg::job_type job
);
   import cia_pkg::*;

   localparam int W = DataWidth;
   localparam int SW = $clog2(W) + 1;

   logic signed [W-1:0] a;
   logic signed [W-1:0] b;
   logic signed [W-1:0] sum;
   logic signed [W-1:0] dif;
   logic signed [W-1:0] r;
   logic [2:0]          err;
   logic                big_shift;
   logic [SW-2:0]       sh;
   class_type           cls;
   logic                min_a;

   assign a = req.operand_a[W-1:0];
   assign b = req.operand_b[W-1:0];
   assign sum = a + b;
   assign dif = a - b;
   assign big_shift = (b >= W);
   assign sh = b[SW-2:0];
   assign min_a = (a == {1'b1, {(W-1){1'b0}}});

   // Classification and the operations settled in the front end.
   always_comb begin
      r = '0;
      err = ERR_NONE;
      cls = CLS_DONE;
      case (action_type'(req.action))
         ACT_ADD: begin
            r = sum;
            if (a[W-1] == b[W-1] && sum[W-1] != a[W-1]) err = ERR_OVF;
         end
         ACT_SUB: begin
            r = dif;
            if (a[W-1] != b[W-1] && dif[W-1] != a[W-1]) err = ERR_OVF;
         end
         ACT_MUL: cls = CLS_MUL;
         ACT_DIV, ACT_MOD: begin
            if (b == '0) err = ERR_DIV0;
            else if (min_a && b == '1) err = ERR_OVF;
            else cls = CLS_DIV;
         end
         ACT_POW: begin
            if (b[W-1]) err = ERR_NEGEXP;
            else if (b == '0) r = W'(1);
            else if (a == '0 || a == W'(1)) r = a;
            else if (a == '1) r = b[0] ? a : W'(1);
            else if (big_shift) err = ERR_OVF;
            else cls = CLS_POW;
         end
         ACT_SHL: begin
            if (b[W-1]) err = ERR_NEGSHIFT;
            else if (!big_shift) r = a <<< sh;
         end
         ACT_SHR: begin
            if (b[W-1]) err = ERR_NEGSHIFT;
            else if (big_shift) r = {W{a[W-1]}};
            else r = a >>> sh;
         end
         ACT_NOT: r = ~a;
         ACT_AND: r = a & b;
         ACT_OR:  r = a | b;
         ACT_XOR: r = a ^ b;
         ACT_NEG: r = -a;
         default: r = '0;
      endcase
      if (err != ERR_NONE) r = '0;
   end

   always_comb begin
      job.cls = cls;
      job.want_rem = (action_type'(req.action) == ACT_MOD);
      job.a = FieldWidth'(a);
      job.b = FieldWidth'(b);
      job.value = FieldWidth'(r);
      job.error_code = err;
   end

endmodule

// ===== hw/rtl/cia_queue.sv =====
module cia_queue #(
   parameter int Depth = cia_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cia_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output cia_pkg::job_type pop_data,
   output logic             empty
);
   import cia_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   job_type          mem_ff [Depth];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;

   assign full = (cnt_ff == (AW+1)'(Depth));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wr_in = (wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_in = (rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(Depth)) else $error("queue count beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> full) else $error("full queue lost its entry");
   a_empty_stays: assert property (@(posedge clock) disable iff (reset)
      empty && !push |=> empty) else $error("empty queue gained an entry");

endmodule

// ===== hw/rtl/cia_back.sv =====
module cia_back #(
   parameter int DataWidth = cia_pkg::DataWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  cia_pkg::job_type job,
   output logic             job_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cia_pkg::rsp_type rsp_data
);
   import cia_pkg::*;

   localparam int W = DataWidth;
   localparam int CW = $clog2(W + 1);
   localparam int HW = (W + 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_MFIN, ST_DIV, ST_POW, ST_OUT
   } state_type;

   // Magnitude multiply of W x W by halves, one partial product a cycle.
   state_type         state_ff, state_in;
   logic [W-1:0]      ma_ff, ma_in;      // multiplicand / divisor magnitude
   logic [W-1:0]      mb_ff, mb_in;      // multiplier magnitude
   logic [2*W-1:0]    acc_ff, acc_in;    // product or remainder:quotient
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [1:0]        ph_ff, ph_in;
   logic              neg_ff, neg_in;
   logic              rem_ff, rem_in;
   logic              dneg_ff, dneg_in;
   logic [W-1:0]      pbase_ff, pbase_in;
   logic              pow_ff, pow_in;
   rsp_type           out_ff, out_in;

   logic [W-1:0]      ja, jb, abs_a, abs_b;
   logic [HW-1:0]     x_part, y_part;
   logic [2*HW-1:0]   pp;
   logic [2*W-1:0]    pp_sh;
   logic [W:0]        trial;
   logic [W-1:0]      lo, hi, limit, mres;
   logic              movf;

   assign ja = job.a[W-1:0];
   assign jb = job.b[W-1:0];
   assign abs_a = ja[W-1] ? -ja : ja;
   assign abs_b = jb[W-1] ? -jb : jb;

   // One half-by-half partial product, selected by phase.
   assign x_part = ph_ff[0] ? HW'(ma_ff >> HW) : HW'(ma_ff);
   assign y_part = ph_ff[1] ? HW'(mb_ff >> HW) : HW'(mb_ff);
   assign pp = x_part * y_part;
   assign pp_sh = (2*W)'(pp) << (HW * (32'(ph_ff[0]) + 32'(ph_ff[1])));

   // Overflow check on the finished magnitude product.
   assign lo = acc_ff[W-1:0];
   assign hi = acc_ff[2*W-1:W];
   assign limit = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
   assign movf = (hi != '0) || (lo > limit);
   assign mres = neg_ff ? -lo : lo;

   // Restoring division step: acc holds remainder high, dividend low.
   assign trial = acc_ff[2*W-1:W-1] - {1'b0, ma_ff};

   assign job_ready = (state_ff == ST_IDLE) ||
                      (state_ff == ST_OUT && rsp_ready);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff; cnt_in = cnt_ff;
      ph_in = ph_ff; neg_in = neg_ff; rem_in = rem_ff; dneg_in = dneg_ff;
      pbase_in = pbase_ff; pow_in = pow_ff;
      out_in = out_ff;
      case (state_ff)
         ST_MUL: begin
            acc_in = acc_ff + pp_sh;
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd3) state_in = pow_ff ? ST_POW : ST_MFIN;
         end
         ST_MFIN: begin
            // acc holds the finished product.
            out_in.value = FieldWidth'(signed'(movf ? '0 : mres));
            out_in.error_code = movf ? ERR_OVF : ERR_NONE;
            state_in = ST_OUT;
         end
         ST_POW: begin
            // acc holds the product of the last multiply.
            if (movf) begin
               out_in.value = '0;
               out_in.error_code = ERR_OVF;
               state_in = ST_OUT;
            end else begin
               if (cnt_ff == CW'(1)) begin
                  out_in.value = FieldWidth'(signed'(mres));
                  out_in.error_code = ERR_NONE;
                  state_in = ST_OUT;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
                  ma_in = mres[W-1] ? -mres : mres;
                  neg_in = mres[W-1] ^ pbase_ff[W-1];
                  acc_in = '0;
                  ph_in = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            if (!trial[W]) acc_in = {trial[W-1:0], acc_ff[W-2:0], 1'b1};
            else acc_in = {acc_ff[2*W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) state_in = ST_OUT;
         end
         default: ;
      endcase

      // Result formatting at the end of division.
      if (state_ff == ST_DIV && cnt_ff == CW'(1)) begin
         if (!rem_ff) begin
            out_in.value = FieldWidth'(signed'(neg_ff ? -acc_in[W-1:0]
                                                      : acc_in[W-1:0]));
         end else begin
            out_in.value = FieldWidth'(signed'(dneg_ff ? -acc_in[2*W-1:W]
                                                       : acc_in[2*W-1:W]));
         end
         out_in.error_code = ERR_NONE;
      end

      if (job_ready) begin
         if (job_valid) begin
            pow_in = 1'b0;
            rem_in = job.want_rem;
            dneg_in = ja[W-1];
            acc_in = '0;
            ph_in = '0;
            case (job.cls)
               CLS_MUL: begin
                  ma_in = abs_a; mb_in = abs_b;
                  neg_in = ja[W-1] ^ jb[W-1];
                  state_in = ST_MUL;
               end
               CLS_POW: begin
                  // acc starts from base * 1 via the multiplier.
                  ma_in = '0; ma_in[0] = 1'b1;
                  mb_in = abs_a;
                  neg_in = ja[W-1];
                  pbase_in = ja;
                  cnt_in = CW'(jb);
                  pow_in = 1'b1;
                  state_in = ST_MUL;
               end
               CLS_DIV: begin
                  ma_in = abs_b;
                  acc_in = {{W{1'b0}}, abs_a};
                  neg_in = ja[W-1] ^ jb[W-1];
                  cnt_in = CW'(W);
                  state_in = ST_DIV;
               end
               default: begin
                  out_in.value = job.value;
                  out_in.error_code = job.error_code;
                  state_in = ST_OUT;
               end
            endcase
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in; cnt_ff <= cnt_in;
      ph_ff <= ph_in; neg_ff <= neg_in; rem_ff <= rem_in; dneg_ff <= dneg_in;
      pbase_ff <= pbase_in; pow_ff <= pow_in;
      out_ff <= out_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_ready_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !job_ready) else $error("ready during divide");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_ff.error_code != ERR_NONE |-> out_ff.value == '0)
      else $error("error result not zero");

endmodule

// ===== hw/rtl/checked_integer_alu.sv =====
// Overflow-checked signed integer ALU.
// Request channel: req_valid/req_ready carrying req_data (action, operand_a,
// operand_b). Response channel: rsp_valid/rsp_ready carrying rsp_data
// (value, error_code); one response for every request, in order.
// The front end decodes each request in the accepting cycle and settles all
// simple operations (add, sub, shifts, logic, negate) and every error case
// but multiply and power overflow. Every request then enters a two-entry
// queue, which the back end drains. A simple operation's response is
// registered in the queue entry and then in the back end's output register.
// Multiply forms one half-width partial product a cycle in the back end, then
// checks overflow. Divide and remainder produce one quotient bit a cycle.
// Power repeats the multiply and its check, up to DATA_WIDTH-1 multiplications.
// Simple operations sustain one request a cycle while the receiver takes
// responses; the rate of the others is set by the shared multiply/divide unit.
// Reset empties the queue and the back end; no response is pending after it.
// When the receiver stalls, the response holds, the queue fills and then
// req_ready falls.
module checked_integer_alu #(
   parameter int DATA_WIDTH = cia_pkg::DataWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cia_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cia_pkg::rsp_type rsp_data
);
   import cia_pkg::*;

   job_type front_job, q_job;
   logic    q_full, q_empty, back_ready;
   rsp_type back_rsp;

   cia_front #(.DataWidth(DATA_WIDTH)) u_front (
      .req (req_data),
      .job (front_job)
   );

   cia_queue #(.Depth(QueueDepthDefault)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_job),
      .full      (q_full),
      .pop       (back_ready),
      .pop_data  (q_job),
      .empty     (q_empty)
   );

   cia_back #(.DataWidth(DATA_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job       (q_job),
      .job_ready (back_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (back_rsp)
   );

   assign req_ready = !q_full;

   // Sign-extend the result to the field width.
   always_comb begin
      rsp_data = back_rsp;
      rsp_data.value = FieldWidth'(signed'(back_rsp.value[DATA_WIDTH-1:0]));
   end

endmodule
